### design/slfr_pkg.sv
// Shared types and constants for the sync/length frame reassembler.
// No dependencies; used by slfr_step and the top level.
`default_nettype none

package slfr_pkg;

  localparam int          BUFFER_BYTES_DEF = 512;
  localparam logic [7:0]  SYNC_RESET       = 8'hA5;
  localparam logic [8:0]  LENGTH_EXTRA     = 9'd4;
  localparam int          HDR_BYTES        = 3;
  localparam int          COUNT_W          = 9;   // open frame holds at most 258 bytes
  localparam int          MLEN_W           = 10;
  localparam int          CFG_ADDR_W       = 3;
  localparam int          CFG_DATA_W       = 32;

  // register index, taken from paddr[2]
  localparam logic        REG_SYNC         = 1'b0;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               dropping;
    logic [7:0]         hdr0;
    logic [7:0]         hdr1;
    logic [7:0]         hdr2;
  } slfr_state_t;

  typedef struct packed {
    logic [8:0] frame_length;
    logic [7:0] header_byte0;
    logic [7:0] header_byte1;
    logic [7:0] header_byte2;
  } slfr_result_t;

endpackage

`default_nettype wire

### design/slfr_if.sv
// Valid/ready channel interfaces for the frame reassembler input and result streams.
// Depends on nothing; field widths follow the block's item formats.
`default_nettype none

interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;
  logic [9:0] message_length;

  modport source (output valid, data_byte, first_of_message, message_length, input ready);
  modport sink   (input valid, data_byte, first_of_message, message_length, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] frame_length;
  logic [7:0] header_byte0;
  logic [7:0] header_byte1;
  logic [7:0] header_byte2;

  modport source (output valid, frame_length, header_byte0, header_byte1, header_byte2,
                  input ready);
  modport sink   (input valid, frame_length, header_byte0, header_byte1, header_byte2,
                  output ready);
endinterface

`default_nettype wire

### design/slfr_step.sv
// Per-byte next-state and frame-complete logic of the reassembler.
// Depends on slfr_pkg.
`default_nettype none

module slfr_step
  import slfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  slfr_state_t        state_i,
  input  logic [7:0]         data_byte,
  input  logic               first_of_message,
  input  logic [MLEN_W-1:0]  message_length,
  input  logic [7:0]         sync_value,
  output slfr_state_t        state_o,
  output logic               done_o,
  output slfr_result_t       result_o
);

  localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
  localparam int MW    = (BUF_W > MLEN_W) ? BUF_W : MLEN_W;

  logic [MW-1:0]      mlen_w;
  logic [MW-1:0]      mlen_sat;
  logic [MW:0]        sum;
  logic               overflow;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic               drop;
  slfr_state_t        st;
  logic               hit;

  always_comb begin
    mlen_w   = MW'(message_length);
    mlen_sat = (mlen_w > MW'(BUFFER_BYTES)) ? MW'(BUFFER_BYTES) : mlen_w;
    sum      = (MW+1)'(state_i.count) + (MW+1)'(mlen_sat);
    overflow = sum > (MW+1)'(BUFFER_BYTES);

    count_a = (first_of_message && overflow) ? '0 : state_i.count;
    drop    = first_of_message ? ((count_a == '0) && (data_byte != sync_value))
                               : state_i.dropping;

    st          = state_i;
    st.count    = count_a;
    st.dropping = drop;
    hit         = 1'b0;
    count_b     = count_a + COUNT_W'(1);

    if (!drop) begin
      case (count_a)
        COUNT_W'(0): st.hdr0 = data_byte;
        COUNT_W'(1): st.hdr1 = data_byte;
        COUNT_W'(2): st.hdr2 = data_byte;
        default: ;
      endcase
      // length field sits in the third byte; frame is that plus four
      hit      = (count_b >= COUNT_W'(HDR_BYTES)) &&
                 (count_b == ({1'b0, st.hdr2} + LENGTH_EXTRA));
      st.count = hit ? '0 : count_b;
    end

    state_o                = st;
    done_o                 = hit;
    result_o.frame_length  = count_b;
    result_o.header_byte0  = st.hdr0;
    result_o.header_byte1  = st.hdr1;
    result_o.header_byte2  = st.hdr2;
  end

endmodule

`default_nettype wire

### design/sync_length_frame_reassembler.sv
// Top level of the sync/length frame reassembler: APB register, state and result registers.
// Depends on slfr_pkg, slfr_if and slfr_step.
// Latency: a frame's result is valid the cycle after its last byte is accepted.
// Throughput: one byte per cycle; in_ch.ready drops only while a result waits
// and out_ch.ready is low. Reset (rst_n low, synchronous) clears the byte count,
// drop flag and result valid, and sets sync_value to 0xA5.
`default_nettype none

module sync_length_frame_reassembler
  import slfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  slfr_in_if.sink                    in_ch,
  slfr_out_if.source                 out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [7:0]   sync_value_r;
  slfr_state_t  state_r;
  slfr_state_t  state_nxt;
  logic         done;
  slfr_result_t result;
  slfr_result_t result_r;
  logic         out_valid_r;
  logic         in_fire;
  logic         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_SYNC) ? CFG_DATA_W'(sync_value_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_SYNC)) begin
      sync_value_r <= pwdata[7:0];
    end
  end

  slfr_step #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_step (
    .state_i          (state_r),
    .data_byte        (in_ch.data_byte),
    .first_of_message (in_ch.first_of_message),
    .message_length   (in_ch.message_length),
    .sync_value       (sync_value_r),
    .state_o          (state_nxt),
    .done_o           (done),
    .result_o         (result)
  );

  // output register frees up in the same cycle it is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.count    <= '0;
      state_r.dropping <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire && done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && done) begin
      result_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_length = result_r.frame_length;
  assign out_ch.header_byte0 = result_r.header_byte0;
  assign out_ch.header_byte1 = result_r.header_byte1;
  assign out_ch.header_byte2 = result_r.header_byte2;

endmodule

`default_nettype wire
